// ===== rtl/hcs_pkg.sv =====
// shared types and constants of the histogram contrast stretch core
// no dependencies; imported by every rtl module of the block

package hcs_pkg;

  localparam int PixW     = 8;
  localparam int StatW    = 2;
  localparam int DivSteps = 8;                 // quotient bits, one per step
  localparam int CntW     = $clog2(DivSteps);
  localparam int NumW     = 2 * PixW + 1;      // 2*d*255 + span
  localparam int DivW     = PixW + 1;          // 2*span

  typedef logic [PixW-1:0]  pix_t;
  typedef logic [StatW-1:0] stat_t;
  typedef logic [CntW-1:0]  cnt_t;

  localparam pix_t  PixMax       = {PixW{1'b1}};
  localparam pix_t  PixZero      = '0;
  localparam stat_t STAT_OK      = 2'd0;
  localparam stat_t STAT_NO_SCAN = 2'd1;
  localparam stat_t STAT_FLAT    = 2'd2;
  localparam stat_t STAT_BAD     = 2'd3;
  localparam cnt_t  CntLast      = cnt_t'(DivSteps - 1);

  // controller to datapath
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic div_step;    // one restoring division step
    logic div_last;    // final step, write quotient to output register
  } hcs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_stretch;  // current input is a stretch item
    logic need_div;    // stretch item needs the divider
  } hcs_sts_t;

endpackage

// ===== rtl/hcs_ctrl.sv =====
// controller of the contrast stretch core: handshakes and divider sequencing
// depends on hcs_pkg

module hcs_ctrl
  import hcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  hcs_sts_t sts,
  output hcs_cmd_t cmd
);

  typedef enum logic {ST_IDLE, ST_DIV} state_t;

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  assign cmd.accept   = accept;
  assign cmd.div_step = (state_r == ST_DIV);
  assign cmd.div_last = (state_r == ST_DIV) && (cnt_r == CntLast);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept && sts.is_stretch) begin
          if (sts.need_div) begin
            state_nxt = ST_DIV;
            cnt_nxt   = '0;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + cnt_t'(1);
        if (cnt_r == CntLast) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/hcs_dp.sv =====
// datapath of the contrast stretch core: bounds, serial divider, result register
// depends on hcs_pkg

module hcs_dp
  import hcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_req_type,
  input  pix_t     in_pixel,
  input  logic     in_first,
  input  hcs_cmd_t cmd,
  output hcs_sts_t sts,
  output pix_t     out_pixel_out,
  output stat_t    out_status
);

  pix_t  min_r, min_nxt;
  pix_t  max_r, max_nxt;
  logic  seen_r, seen_nxt;
  logic [DivW-1:0] rem_r, rem_nxt;
  logic [DivW-1:0] div_r, div_nxt;
  pix_t  quo_r, quo_nxt;
  pix_t  pix_out_r, pix_out_nxt;
  stat_t stat_r, stat_nxt;

  pix_t  span, delta;
  logic [NumW-1:0] num;
  logic  direct;
  pix_t  direct_pix;
  stat_t direct_stat;
  logic [DivW:0] rem_sh, rem_diff;
  logic  ge;

  assign span  = max_r - min_r;
  assign delta = in_pixel - min_r;
  // round half up: (2*d*255 + span) / (2*span), with d*510 = d*512 - d*2
  assign num = {delta, 9'b0} - {{(NumW-PixW-1){1'b0}}, delta, 1'b0}
             + {{(NumW-PixW){1'b0}}, span};

  always_comb begin
    direct      = 1'b1;
    direct_pix  = in_pixel;
    direct_stat = STAT_OK;
    if (!seen_r) begin
      direct_stat = STAT_NO_SCAN;
    end else if (min_r == PixZero && max_r == PixMax) begin
      direct_stat = STAT_OK;
    end else if (max_r <= min_r) begin
      direct_stat = STAT_FLAT;
    end else if (in_pixel < min_r) begin
      direct_pix = PixZero;
    end else if (in_pixel > max_r) begin
      direct_pix = PixMax;
    end else begin
      direct = 1'b0;
    end
  end

  assign sts.is_stretch = in_req_type;
  assign sts.need_div   = !direct;

  // restoring division step, one quotient bit
  assign rem_sh   = {rem_r, quo_r[PixW-1]};
  assign ge       = rem_sh >= {1'b0, div_r};
  assign rem_diff = rem_sh - {1'b0, div_r};

  always_comb begin
    min_nxt     = min_r;
    max_nxt     = max_r;
    seen_nxt    = seen_r;
    rem_nxt     = rem_r;
    div_nxt     = div_r;
    quo_nxt     = quo_r;
    pix_out_nxt = pix_out_r;
    stat_nxt    = stat_r;
    if (cmd.accept && !in_req_type) begin
      seen_nxt = 1'b1;
      if (in_first) begin
        min_nxt = in_pixel;
        max_nxt = in_pixel;
      end else begin
        if (in_pixel < min_r) min_nxt = in_pixel;
        if (in_pixel > max_r) max_nxt = in_pixel;
      end
    end
    if (cmd.accept && in_req_type) begin
      if (direct) begin
        pix_out_nxt = direct_pix;
        stat_nxt    = direct_stat;
      end else begin
        rem_nxt = num[NumW-1:PixW];
        quo_nxt = num[PixW-1:0];
        div_nxt = {span, 1'b0};
      end
    end
    if (cmd.div_step) begin
      rem_nxt = ge ? rem_diff[DivW-1:0] : rem_sh[DivW-1:0];
      quo_nxt = {quo_r[PixW-2:0], ge};
      if (cmd.div_last) begin
        pix_out_nxt = {quo_r[PixW-2:0], ge};
        stat_nxt    = STAT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= PixMax;
      max_r  <= PixZero;
      seen_r <= 1'b0;
    end else begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
    quo_r     <= quo_nxt;
    pix_out_r <= pix_out_nxt;
    stat_r    <= stat_nxt;
  end

  assign out_pixel_out = pix_out_r;
  assign out_status    = stat_r;

endmodule

// ===== rtl/histogram_contrast_stretch_core.sv =====
// Min/max linear contrast stretch of an 8-bit grey image sent twice. Scan
// transfers (req_type 0) track a running minimum and maximum, with first
// restarting both, and give no result. Each stretch transfer (req_type 1)
// gives one result: round((p-min)*255/(max-min)) with halves rounded up,
// status 0. Pixels outside the bounds saturate to 0 or 255, and bounds of 0
// and 255 pass the pixel unchanged. A stretch before any scan returns the
// pixel with status 1, a flat image (max equals min) the pixel with status 2.
// Timing: a stretch that divides runs a bit-serial restoring divider, one
// quotient bit per step, and holds off new transfers until the quotient is
// written to the result register. The result register lets a new transfer
// enter in the cycle the previous result is taken.
// depends on hcs_pkg, hcs_ctrl, hcs_dp

module histogram_contrast_stretch_core
  import hcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  // input channel
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  in_req_type,
  input  pix_t  in_pixel,
  input  logic  in_first,
  // result channel
  output logic  out_valid,
  input  logic  out_stall,
  output pix_t  out_pixel_out,
  output stat_t out_status
);

  hcs_cmd_t cmd;  // sequencing commands
  hcs_sts_t sts;  // decode of the current input against the bounds

  // handshakes, result valid and divider step count
  hcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // bounds tracking, special cases, divider and result register
  hcs_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_req_type   (in_req_type),
    .in_pixel      (in_pixel),
    .in_first      (in_first),
    .cmd           (cmd),
    .sts           (sts),
    .out_pixel_out (out_pixel_out),
    .out_status    (out_status)
  );

endmodule

// ===== rtl/hcs_checker.sv =====
// port-level checks of the contrast stretch core, bound to the top level
// depends on hcs_pkg and histogram_contrast_stretch_core

module hcs_checker
  import hcs_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_stall,
  input logic  in_req_type,
  input logic  out_valid,
  input logic  out_stall,
  input pix_t  out_pixel_out,
  input stat_t out_status
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out) && $stable(out_status))
    else $error("result changed while stalled");

  // only the three defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != STAT_BAD)
    else $error("undefined status code");

  // a scan transfer never produces a result
  a_scan_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_req_type && !out_valid |=> !out_valid)
    else $error("scan transfer produced a result");

  // a stretch transfer either answers next cycle or holds off further input
  a_stretch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_req_type && !out_valid |=> out_valid || in_stall)
    else $error("stretch transfer lost");

endmodule

bind histogram_contrast_stretch_core hcs_checker u_hcs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_req_type   (in_req_type),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pixel_out (out_pixel_out),
  .out_status    (out_status)
);

// ===== verif/tb_histogram_contrast_stretch_core.sv =====
// self-checking testbench for histogram_contrast_stretch_core: min/max bound
// tracking, stretch rounding, saturation and the pass-through status cases
// depends on hcs_pkg and the rtl of histogram_contrast_stretch_core

module tb_histogram_contrast_stretch_core;
  import hcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_SCAN    = 1'b0;
  localparam logic REQ_STRETCH = 1'b1;
  localparam int   RandItems   = 600;
  localparam int   DrainLimit  = 5000;

  // one stretched pixel as it leaves the block
  typedef struct packed {
    pix_t  pixel;
    stat_t status;
  } graded_pix_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  in_req_type = REQ_SCAN;
  pix_t  in_pixel = PixZero;
  logic  in_first = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  pix_t  out_pixel_out;
  stat_t out_status;

  // predicted bounds, same reset values as the block
  pix_t lo_bound = PixMax;
  pix_t hi_bound = PixZero;
  bit   scanned  = 1'b0;

  graded_pix_t stretched_q[$];
  int          mismatches = 0;

  // sender pacing: bursts of transfers separated by idle gaps
  bit idle_on    = 1'b1;
  int burst_left = 0;

  histogram_contrast_stretch_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_pixel      (in_pixel),
    .in_first      (in_first),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_status    (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // scan transfer: restart or widen the running bounds
  function automatic void track_bounds(pix_t p, logic restart);
    if (restart) begin
      lo_bound = p;
      hi_bound = p;
    end else begin
      if (p < lo_bound) lo_bound = p;
      if (p > hi_bound) hi_bound = p;
    end
    scanned = 1'b1;
  endfunction

  // stretch transfer: exact integer form of round((p-lo)*255/(hi-lo)),
  // halves going up
  function automatic graded_pix_t stretch_pixel(pix_t p);
    graded_pix_t r;
    int unsigned span;
    int unsigned num;
    r.pixel  = p;
    r.status = STAT_OK;
    if (!scanned) begin
      r.status = STAT_NO_SCAN;
    end else if (lo_bound == PixZero && hi_bound == PixMax) begin
      r.status = STAT_OK;                    // full range, identity
    end else if (hi_bound <= lo_bound) begin
      r.status = STAT_FLAT;
    end else if (p < lo_bound) begin
      r.pixel = PixZero;
    end else if (p > hi_bound) begin
      r.pixel = PixMax;
    end else begin
      span    = 32'(hi_bound - lo_bound);
      num     = 2 * 32'(p - lo_bound) * 255 + span;
      r.pixel = pix_t'(num / (2 * span));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one transfer per call, valid stays high into the next call
  // ---------------------------------------------------------------------------
  task automatic push_pixel(logic req, pix_t p, logic restart);
    int gap;
    if (idle_on && burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_pixel    <= p;
    in_first    <= restart;
    // wait for the transfer; stall is sampled as it was before the edge
    do @(posedge clk); while (in_stall);
    if (req == REQ_STRETCH) stretched_q.push_back(stretch_pixel(p));
    else track_bounds(p, restart);
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    graded_pix_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (stretched_q.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, actual pixel %0d status %0d", $time,
                 out_pixel_out, out_status);
      end else begin
        want = stretched_q.pop_front();
        if (out_pixel_out !== want.pixel) begin
          mismatches++;
          $display("%0t: pixel_out expected %0d actual %0d", $time,
                   want.pixel, out_pixel_out);
        end
        if (out_status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_status);
        end
      end
    end
  end

  // receiver back-pressure: switches between several stall patterns
  int stall_mode = 0;
  int stall_run  = 0;
  int stall_tick = 0;
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(8, 40);
    end
    stall_run--;
    stall_tick++;
    case (stall_mode)
      0: out_stall <= 1'b0;                              // free running
      1: out_stall <= ($urandom_range(0, 3) == 0);       // light stalls
      2: out_stall <= ($urandom_range(0, 3) != 0);       // heavy stalls
      default: out_stall <= stall_tick[0];               // alternating
    endcase
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // stretch before anything was scanned, pixel comes back with status 1
  task automatic test_before_scan();
    push_pixel(REQ_STRETCH, PixZero, 1'b0);
    push_pixel(REQ_STRETCH, PixMax, 1'b1);
    push_pixel(REQ_STRETCH, 8'h5A, 1'b0);
  endtask

  // scan without first straight after reset acts as a restart, then a
  // single-valued image is flat
  task automatic test_flat_after_reset();
    push_pixel(REQ_SCAN, 8'd100, 1'b0);
    push_pixel(REQ_SCAN, 8'd100, 1'b0);
    push_pixel(REQ_STRETCH, 8'd100, 1'b0);
    push_pixel(REQ_STRETCH, 8'hA5, 1'b0);
  endtask

  // bounds of 0 and 255 pass the pixel unchanged
  task automatic test_full_range();
    push_pixel(REQ_SCAN, PixMax, 1'b1);
    push_pixel(REQ_SCAN, PixZero, 1'b0);
    push_pixel(REQ_STRETCH, PixZero, 1'b0);
    push_pixel(REQ_STRETCH, 8'd128, 1'b0);
    push_pixel(REQ_STRETCH, PixMax, 1'b0);
  endtask

  // pixels outside the bounds saturate; first is ignored on stretch transfers
  task automatic test_saturation();
    push_pixel(REQ_SCAN, 8'd50, 1'b1);
    push_pixel(REQ_SCAN, 8'd200, 1'b0);
    push_pixel(REQ_STRETCH, 8'd10, 1'b0);
    push_pixel(REQ_STRETCH, 8'd250, 1'b1);
    push_pixel(REQ_STRETCH, 8'd50, 1'b0);
    push_pixel(REQ_STRETCH, 8'd200, 1'b0);
    push_pixel(REQ_STRETCH, 8'd125, 1'b1);
  endtask

  // span of two puts an exact half on the middle pixel, it rounds up
  task automatic test_half_rounding();
    push_pixel(REQ_SCAN, PixZero, 1'b1);
    push_pixel(REQ_SCAN, 8'd2, 1'b0);
    push_pixel(REQ_STRETCH, 8'd1, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // random images: scan pass then stretch pass of the same pixels
  // ---------------------------------------------------------------------------
  task automatic test_random_images();
    pix_t img[16];
    int   n_sent;
    int   kind;
    int   n_pix;
    int   lo;
    int   hi;
    logic restart;
    n_sent = 0;
    while (n_sent < RandItems) begin
      kind    = $urandom_range(0, 99);
      n_pix   = $urandom_range(1, 12);
      idle_on = ($urandom_range(0, 3) != 0);
      restart = ($urandom_range(0, 9) != 0);
      lo      = $urandom_range(0, 255);
      hi      = $urandom_range(lo, 255);
      if (kind < 8) begin
        hi = lo;                                 // flat image
      end else if (kind < 14) begin
        lo = 0;                                  // full range image
        hi = 255;
      end
      if (kind >= 92) begin
        // noise: arbitrary transfers of either type
        for (int i = 0; i < n_pix; i++) begin
          push_pixel(logic'($urandom_range(0, 1)), pix_t'($urandom_range(0, 255)),
                     logic'($urandom_range(0, 1)));
        end
        n_sent += n_pix;
      end else begin
        for (int i = 0; i < n_pix; i++) img[i] = pix_t'($urandom_range(lo, hi));
        if (kind >= 8 && kind < 14) begin
          img[0] = PixZero;
          img[n_pix - 1] = PixMax;
        end
        for (int i = 0; i < n_pix; i++) push_pixel(REQ_SCAN, img[i], restart && i == 0);
        // second pass, now and then a pixel that was never scanned
        for (int i = 0; i < n_pix; i++) begin
          if ($urandom_range(0, 9) == 0) img[i] = pix_t'($urandom_range(0, 255));
          push_pixel(REQ_STRETCH, img[i], logic'($urandom_range(0, 1)));
        end
        n_sent += 2 * n_pix;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_scan();
    test_flat_after_reset();
    test_full_range();
    test_saturation();
    test_half_rounding();
    test_random_images();
    in_valid <= 1'b0;

    // drain outstanding results, then wait on to catch any unexpected extra result
    waited = 0;
    while (stretched_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (stretched_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, stretched_q.size());

    if (mismatches == 0 && stretched_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
